[src/jst_pkg.sv]
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types, codes and defaults for the jagged slot table.
// ----------------------------------------------------------------------------
package jst_pkg;

  localparam int MAX_ROWS_DEF    = 4;
  localparam int MAX_COLS_DEF    = 8;
  localparam int VALUE_WIDTH_DEF = 32;

  // rows that carry a length register
  localparam int CFG_ROWS = 4;

  localparam logic [2:0] NUM_ROWS_RST = 3'd4;
  localparam logic [CFG_ROWS-1:0][3:0] COLS_RST = {4'd3, 4'd4, 4'd6, 4'd5};

  typedef enum logic [1:0] {
    REQ_CLAIM   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_SEARCH  = 2'd2,
    REQ_QUERY   = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_CLAIMED   = 3'd0,
    ST_NO_SLOT   = 3'd1,
    ST_TAKEN     = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_FREE      = 3'd6,
    ST_BUSY      = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    CFG_NUM_ROWS = 3'd0,
    CFG_COLS0    = 3'd1,
    CFG_COLS1    = 3'd2,
    CFG_COLS2    = 3'd3,
    CFG_COLS3    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_RESOLVE,
    S_SCAN
  } state_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [1:0]         found_row;
    logic [2:0]         found_col;
    logic signed [31:0] found_value;
  } res_t;

  typedef struct packed {
    logic [2:0]                num_rows;
    logic [CFG_ROWS-1:0][3:0] cols;
  } cfg_t;

endpackage

[src/jst_slot_mem.sv]
// ----------------------------------------------------------------------------
// jst_slot_mem
// Slot storage: one write port, one registered read port, per-entry valid
// bits so that never-written slots read as empty.
// ----------------------------------------------------------------------------
module jst_slot_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int VW    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [VW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [VW-1:0] wr_data
);

  logic [VW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [VW-1:0]    rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

[src/jst_ctrl.sv]
// ----------------------------------------------------------------------------
// jst_ctrl
// Request sequencer: bounds check, read-modify-write of one slot, and the
// row/column scan for searches with a registered read pipeline.
// ----------------------------------------------------------------------------
module jst_ctrl #(
  parameter int MAX_ROWS    = 4,
  parameter int MAX_COLS    = 8,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  jst_pkg::req_t          req,
  input  jst_pkg::cfg_t          cfg,
  output logic                   done,
  output jst_pkg::res_t          result,
  output logic                   mem_rd_en,
  output logic [AW-1:0]          mem_rd_addr,
  input  logic [VALUE_WIDTH-1:0] mem_rd_data,
  output logic                   mem_wr_en,
  output logic [AW-1:0]          mem_wr_addr,
  output logic [VALUE_WIDTH-1:0] mem_wr_data
);

  import jst_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);

  function automatic logic [CW-1:0] row_len(input logic [3:0] r, input cfg_t c);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < CFG_ROWS; i++) begin
      if (r == 4'(i)) begin
        n = c.cols[i];
      end
    end
    if (int'(n) > MAX_COLS) begin
      return CW'(MAX_COLS);
    end
    return CW'(n);
  endfunction

  state_t state, state_next;
  req_t   req_q;

  logic [RW-1:0] cur_row, cur_row_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic          tag_vld, tag_vld_next;
  logic [RW-1:0] tag_row, tag_row_next;
  logic [CW-1:0] tag_col, tag_col_next;
  logic          done_next;
  res_t          res_next;

  logic [RW-1:0]                 nr;
  logic signed [VALUE_WIDTH-1:0] item_vw;
  logic signed [VALUE_WIDTH-1:0] held;
  logic                          slot_ok;
  logic [AW-1:0]                 slot_addr;
  logic [AW-1:0]                 cur_addr;
  logic                          row_ok;
  logic                          col_ok;
  logic                          issue;
  logic                          hit;
  logic                          scan_end;

  assign nr = (int'(cfg.num_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(cfg.num_rows);
  assign item_vw = VALUE_WIDTH'(req_q.item_value);
  assign held    = mem_rd_data;

  assign slot_ok = (int'(req_q.row_index) < int'(nr)) &&
                   (int'(req_q.col_index) < int'(row_len(req_q.row_index, cfg)));
  assign slot_addr = AW'(int'(req_q.row_index) * MAX_COLS + int'(req_q.col_index));

  assign row_ok   = cur_row < nr;
  assign col_ok   = cur_col < row_len(4'(cur_row), cfg);
  assign issue    = row_ok && col_ok;
  assign cur_addr = AW'(int'(cur_row) * MAX_COLS + int'(cur_col));
  assign hit      = tag_vld && (held == item_vw);
  assign scan_end = !row_ok && !tag_vld;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_ACCESS;
        end
      end
      S_ACCESS: begin
        if (req_q.req_type == REQ_SEARCH) begin
          state_next = S_SCAN;
        end else if (slot_ok) begin
          state_next = S_RESOLVE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RESOLVE: begin
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (hit || scan_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    done_next    = 1'b0;
    res_next     = '0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = slot_addr;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = slot_addr;
    mem_wr_data  = '0;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    tag_vld_next = 1'b0;
    tag_row_next = cur_row;
    tag_col_next = cur_col;
    unique case (state)
      S_IDLE: begin
        cur_row_next = '0;
        cur_col_next = '0;
      end
      S_ACCESS: begin
        if (req_q.req_type != REQ_SEARCH) begin
          if (slot_ok) begin
            mem_rd_en = 1'b1;
          end else begin
            done_next       = 1'b1;
            res_next.status = ST_NO_SLOT;
          end
        end
      end
      S_RESOLVE: begin
        done_next = 1'b1;
        case (req_q.req_type)
          REQ_CLAIM: begin
            if (held == '0) begin
              mem_wr_en            = 1'b1;
              mem_wr_data          = item_vw;
              res_next.status      = ST_CLAIMED;
              res_next.found_value = 32'(item_vw);
            end else begin
              res_next.status      = ST_TAKEN;
              res_next.found_value = 32'(held);
            end
          end
          REQ_RELEASE: begin
            mem_wr_en            = 1'b1;
            res_next.status      = ST_RELEASED;
            res_next.found_value = 32'(held);
          end
          REQ_QUERY: begin
            res_next.status      = (held == '0) ? ST_FREE : ST_BUSY;
            res_next.found_value = 32'(held);
          end
          default: begin
            res_next.status = ST_NOT_FOUND;
          end
        endcase
      end
      S_SCAN: begin
        mem_rd_en    = issue;
        mem_rd_addr  = cur_addr;
        tag_vld_next = issue;
        if (issue) begin
          cur_col_next = cur_col + 1'b1;
        end else if (row_ok) begin
          cur_row_next = cur_row + 1'b1;
          cur_col_next = '0;
        end
        if (hit) begin
          done_next            = 1'b1;
          res_next.status      = ST_FOUND;
          res_next.found_row   = 2'(tag_row);
          res_next.found_col   = 3'(tag_col);
          res_next.found_value = 32'(held);
        end else if (scan_end) begin
          done_next       = 1'b1;
          res_next.status = ST_NOT_FOUND;
        end
      end
      default: begin
        cur_row_next = '0;
        cur_col_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      tag_vld <= 1'b0;
      cur_row <= '0;
      cur_col <= '0;
    end else begin
      state   <= state_next;
      done    <= done_next;
      tag_vld <= tag_vld_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
    end
  end

  always_ff @(posedge clk) begin
    result  <= res_next;
    tag_row <= tag_row_next;
    tag_col <= tag_col_next;
    if (state == S_IDLE && start) begin
      req_q <= req;
    end
  end

endmodule

[src/jagged_slot_table_with_search.sv]
// ----------------------------------------------------------------------------
// jagged_slot_table_with_search
// Occupancy table of slots in rows of differing length, with claim, release,
// search and query requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result
// appears on result for exactly one cycle with done high and cannot be held
// off. Claim, release and query check bounds and read the slot memory in
// S_ACCESS, then decide and write back in S_RESOLVE; a request for a slot
// that does not exist ends after the bounds check. A search walks the slot
// memory one read per cycle within a row, moving on when a row in use is
// done, and ends on the first match; the default table has 18 slots, 4 rows.
// Slots start empty at reset through per-slot valid bits, so no clearing
// pass is needed. Configuration writes take effect at once; the user must
// make them only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module jagged_slot_table_with_search #(
  parameter int MAX_ROWS    = jst_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = jst_pkg::MAX_COLS_DEF,
  parameter int VALUE_WIDTH = jst_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  jst_pkg::req_t req,
  output logic          done,
  output jst_pkg::res_t result,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [3:0]    cfg_data
);

  import jst_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t cfg;

  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  logic [VALUE_WIDTH-1:0] mem_rd_data;
  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [VALUE_WIDTH-1:0] mem_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_rows <= NUM_ROWS_RST;
      cfg.cols     <= COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ROWS: cfg.num_rows <= cfg_data[2:0];
        CFG_COLS0:    cfg.cols[0]  <= cfg_data;
        CFG_COLS1:    cfg.cols[1]  <= cfg_data;
        CFG_COLS2:    cfg.cols[2]  <= cfg_data;
        CFG_COLS3:    cfg.cols[3]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  jst_ctrl #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .cfg         (cfg),
    .done        (done),
    .result      (result),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  jst_slot_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .VW    (VALUE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_FOUND) |->
      (result.found_row == '0 && result.found_col == '0))
    else $error("position fields set outside a found search");

  a_noslot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_NO_SLOT) |-> (result.found_value == '0))
    else $error("value reported for a missing slot");

endmodule
